// ===== sv/bwu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bwu_pkg;
    localparam logic [3:0] OP_STEP = 4'd0;
    localparam logic [3:0] OP_ADD_PC = 4'd1;
    localparam logic [3:0] OP_ADD_W8 = 4'd2;
    localparam logic [3:0] OP_ADD_W16 = 4'd3;
    localparam logic [3:0] OP_DELETE = 4'd4;
    localparam logic [3:0] OP_ENABLE = 4'd5;
    localparam logic [3:0] OP_DISABLE = 4'd6;
    localparam logic [3:0] OP_MEM_WRITE = 4'd7;
    localparam logic [3:0] OP_CONTINUE = 4'd8;
    localparam logic [3:0] OP_SINGLE = 4'd9;
    localparam logic [3:0] OP_NEXT = 4'd10;

    localparam logic [1:0] KIND_PC = 2'd0;
    localparam logic [1:0] KIND_W8 = 2'd1;
    localparam logic [1:0] KIND_W16 = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NO_ENTRY = 2'd2;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] cur_pc;
        logic [15:0] target_addr;
        logic [15:0] match_value;
        logic [3:0]  entry_number;
        logic [7:0]  write_byte;
        logic [15:0] initial_word;
        logic        is_call;
        logic [2:0]  instr_len;
    } cmd_t;

    typedef struct packed {
        logic       halt;
        logic [3:0] hit_number;
        logic [1:0] status;
    } result_t;

    function automatic logic call_opcode(input logic [7:0] b);
        logic r;
        begin
            case (b)
                8'hc4, 8'hcc, 8'hcd, 8'hd4, 8'hdc, 8'he4, 8'hec, 8'hf4: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/bwu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bwu_front #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [3:0]     op,
    input  wire logic [15:0]    cur_pc,
    input  wire logic [15:0]    target_addr,
    input  wire logic [15:0]    match_value,
    input  wire logic [3:0]     entry_number,
    input  wire logic [7:0]     write_byte,
    input  wire logic [15:0]    initial_word,
    input  wire logic [7:0]     instr_byte,
    input  wire logic [2:0]     instr_len,
    output logic                cmd_valid,
    input  wire logic           cmd_take,
    output bwu_pkg::cmd_t       cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    bwu_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    bwu_pkg::cmd_t in_cmd;

    always_comb
    begin
        in_cmd.op = op;
        in_cmd.cur_pc = cur_pc;
        in_cmd.target_addr = target_addr;
        in_cmd.match_value = match_value;
        in_cmd.entry_number = entry_number;
        in_cmd.write_byte = write_byte;
        in_cmd.initial_word = initial_word;
        in_cmd.is_call = bwu_pkg::call_opcode(instr_byte);
        in_cmd.instr_len = instr_len;
    end

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (cmd_take && cmd_valid)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(cmd_take && cmd_valid);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && !cmd_valid && !(push && !full)) |=> cnt_reg == $past(cnt_reg))
        else $error("count moved without transfer");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_take) |=> full) else $error("full dropped without transfer");
endmodule
`default_nettype wire

// ===== sv/bwu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bwu_back #(
    parameter int MAX_SLOTS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_take,
    input  wire bwu_pkg::cmd_t     cmd,
    output logic                   res_valid,
    input  wire logic              res_take,
    output bwu_pkg::result_t       res
);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  kind_reg [MAX_SLOTS];
    logic [15:0] cmp_reg [MAX_SLOTS];
    logic [15:0] addr_reg [MAX_SLOTS];
    logic [15:0] shadow_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] en_reg;
    logic [CW-1:0] count_reg;
    logic single_reg, ret_valid_reg;
    logic [15:0] ret_addr_reg;
    logic [1:0] state_reg;
    logic [CW-1:0] idx_reg;
    bwu_pkg::cmd_t cur_reg;
    bwu_pkg::result_t res_reg;
    logic res_valid_reg;

    logic [IW-1:0] ix;
    logic hits;
    logic [CW-1:0] num;
    logic num_bad;
    logic [15:0] ret_next;

    assign ix = idx_reg[IW-1:0];
    assign num = CW'(cur_reg.entry_number);
    assign num_bad = (cur_reg.entry_number == 4'd0) ||
                     ({{CW{1'b0}}, cur_reg.entry_number} > {4'd0, count_reg});
    assign ret_next = cur_reg.cur_pc + 16'(cur_reg.instr_len);

    always_comb
    begin
        unique case (kind_reg[ix])
            bwu_pkg::KIND_PC: hits = (addr_reg[ix] == cur_reg.cur_pc);
            bwu_pkg::KIND_W8: hits = ({8'd0, shadow_reg[ix][7:0]} == cmp_reg[ix]);
            bwu_pkg::KIND_W16: hits = (shadow_reg[ix] == cmp_reg[ix]);
            default: hits = 1'b0;
        endcase
    end

    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == S_SCAN && idx_reg < count_reg)
        begin
            if (cur_reg.op == bwu_pkg::OP_MEM_WRITE && kind_reg[ix] != bwu_pkg::KIND_PC)
            begin
                if (addr_reg[ix] == cur_reg.target_addr)
                begin
                    shadow_reg[ix][7:0] <= cur_reg.write_byte;
                end
                if (kind_reg[ix] == bwu_pkg::KIND_W16 &&
                    addr_reg[ix] + 16'd1 == cur_reg.target_addr)
                begin
                    shadow_reg[ix][15:8] <= cur_reg.write_byte;
                end
            end
        end
        if (state_reg == S_SHIFT && idx_reg + 1'b1 < count_reg)
        begin
            kind_reg[ix] <= kind_reg[IW'(idx_reg + 1'b1)];
            cmp_reg[ix] <= cmp_reg[IW'(idx_reg + 1'b1)];
            addr_reg[ix] <= addr_reg[IW'(idx_reg + 1'b1)];
            shadow_reg[ix] <= shadow_reg[IW'(idx_reg + 1'b1)];
        end
        if (state_reg == S_DONE && !res_valid_reg && count_reg < CW'(MAX_SLOTS) &&
            (cur_reg.op == bwu_pkg::OP_ADD_PC || cur_reg.op == bwu_pkg::OP_ADD_W8 ||
             cur_reg.op == bwu_pkg::OP_ADD_W16))
        begin
            kind_reg[count_reg[IW-1:0]] <= (cur_reg.op == bwu_pkg::OP_ADD_PC) ? bwu_pkg::KIND_PC :
                (cur_reg.op == bwu_pkg::OP_ADD_W8) ? bwu_pkg::KIND_W8 : bwu_pkg::KIND_W16;
            addr_reg[count_reg[IW-1:0]] <= cur_reg.target_addr;
            cmp_reg[count_reg[IW-1:0]] <= (cur_reg.op == bwu_pkg::OP_ADD_PC) ? 16'd0 :
                cur_reg.match_value;
            shadow_reg[count_reg[IW-1:0]] <= (cur_reg.op == bwu_pkg::OP_ADD_PC) ? 16'd0 :
                cur_reg.initial_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= '0;
            count_reg <= '0;
            single_reg <= 1'b1;
            ret_valid_reg <= 1'b0;
            ret_addr_reg <= '0;
            state_reg <= S_IDLE;
            idx_reg <= '0;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            if (res_take && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        idx_reg <= '0;
                        res_reg <= '0;
                        if (cmd.op == bwu_pkg::OP_STEP || cmd.op == bwu_pkg::OP_MEM_WRITE)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (cur_reg.op == bwu_pkg::OP_STEP && single_reg)
                    begin
                        res_reg.halt <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        if (cur_reg.op == bwu_pkg::OP_STEP && ret_valid_reg &&
                            cur_reg.cur_pc == ret_addr_reg)
                        begin
                            ret_valid_reg <= 1'b0;
                            res_reg.halt <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (cur_reg.op == bwu_pkg::OP_STEP && en_reg[ix] && hits)
                    begin
                        if (kind_reg[ix] != bwu_pkg::KIND_PC)
                        begin
                            en_reg[ix] <= 1'b0;
                        end
                        res_reg.halt <= 1'b1;
                        res_reg.hit_number <= 4'(idx_reg + 1'b1);
                        idx_reg <= count_reg;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SHIFT:
                begin
                    if (idx_reg + 1'b1 < count_reg)
                    begin
                        en_reg[ix] <= en_reg[IW'(idx_reg + 1'b1)];
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        en_reg[IW'(count_reg - 1'b1)] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_IDLE;
                        res_valid_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                        res_valid_reg <= 1'b1;
                        case (cur_reg.op)
                            bwu_pkg::OP_ADD_PC, bwu_pkg::OP_ADD_W8, bwu_pkg::OP_ADD_W16:
                            begin
                                if (count_reg >= CW'(MAX_SLOTS))
                                begin
                                    res_reg.status <= bwu_pkg::ST_FULL;
                                end
                                else
                                begin
                                    en_reg[count_reg[IW-1:0]] <= 1'b1;
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            bwu_pkg::OP_DELETE:
                            begin
                                if (num_bad)
                                begin
                                    res_reg.status <= bwu_pkg::ST_NO_ENTRY;
                                end
                                else
                                begin
                                    idx_reg <= num - 1'b1;
                                    state_reg <= S_SHIFT;
                                    res_valid_reg <= 1'b0;
                                end
                            end
                            bwu_pkg::OP_ENABLE, bwu_pkg::OP_DISABLE:
                            begin
                                if (num_bad)
                                begin
                                    res_reg.status <= bwu_pkg::ST_NO_ENTRY;
                                end
                                else
                                begin
                                    en_reg[IW'(num - 1'b1)] <= (cur_reg.op == bwu_pkg::OP_ENABLE);
                                end
                            end
                            bwu_pkg::OP_CONTINUE: single_reg <= 1'b0;
                            bwu_pkg::OP_SINGLE: single_reg <= 1'b1;
                            bwu_pkg::OP_NEXT:
                            begin
                                if (cur_reg.is_call)
                                begin
                                    single_reg <= 1'b0;
                                    ret_valid_reg <= 1'b1;
                                    ret_addr_reg <= ret_next;
                                end
                                else
                                begin
                                    single_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SLOTS)) else $error("slot count overflow");
    a_hit_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.hit_number != 4'd0) |-> res_reg.halt)
        else $error("hit without halt");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> state_reg != S_IDLE) else $error("command not started");
endmodule
`default_nettype wire

// ===== sv/breakpoint_watch_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Plain commands go straight to the done state; step and memory write first scan the slots,
// unless single-stepping halts a step at once. A delete moves each later entry down during compaction.
// One item is processed at a time; the slot scan, one entry per cycle, sets the rate.
// A two-entry queue lets new items be taken while the back end works or a result waits.
// Reset is asynchronous, active low: the table empties and single-step mode is set.
module breakpoint_watch_unit #(
    parameter int MAX_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [3:0]  op,
    input  wire logic [15:0] cur_pc,
    input  wire logic [15:0] target_addr,
    input  wire logic [15:0] match_value,
    input  wire logic [3:0]  entry_number,
    input  wire logic [7:0]  write_byte,
    input  wire logic [15:0] initial_word,
    input  wire logic [7:0]  instr_byte,
    input  wire logic [2:0]  instr_len,
    output logic             empty,
    input  wire logic        pop,
    output logic             halt,
    output logic [3:0]       hit_number,
    output logic [1:0]       status
);
    bwu_pkg::cmd_t cmd;
    bwu_pkg::result_t res;
    logic cmd_valid, cmd_take, res_valid;

    bwu_front #(.DEPTH(2)) u_front (
        .clk, .rst_n, .push, .full, .op, .cur_pc, .target_addr, .match_value,
        .entry_number, .write_byte, .initial_word, .instr_byte, .instr_len,
        .cmd_valid, .cmd_take, .cmd
    );

    bwu_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
        .res_valid, .res_take(pop), .res
    );

    assign empty = !res_valid;
    assign halt = res.halt;
    assign hit_number = res.hit_number;
    assign status = res.status;
endmodule
`default_nettype wire

// ===== dv/breakpoint_watch_unit_test.sv =====
`timescale 1ns / 1ps
module breakpoint_watch_unit_test;

    localparam int NSLOT = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [3:0]  op;
    logic [15:0] cur_pc;
    logic [15:0] target_addr;
    logic [15:0] match_value;
    logic [3:0]  entry_number;
    logic [7:0]  write_byte;
    logic [15:0] initial_word;
    logic [7:0]  instr_byte;
    logic [2:0]  instr_len;
    logic        empty;
    logic        pop;
    logic        halt;
    logic [3:0]  hit_number;
    logic [1:0]  status;

    breakpoint_watch_unit #(.MAX_SLOTS(NSLOT)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .op(op),
        .cur_pc(cur_pc),
        .target_addr(target_addr),
        .match_value(match_value),
        .entry_number(entry_number),
        .write_byte(write_byte),
        .initial_word(initial_word),
        .instr_byte(instr_byte),
        .instr_len(instr_len),
        .empty(empty),
        .pop(pop),
        .halt(halt),
        .hit_number(hit_number),
        .status(status)
    );

    // Predictor state.
    logic [1:0]  tbl_kind [NSLOT];
    logic        tbl_on [NSLOT];
    logic [15:0] tbl_cmp [NSLOT];
    logic [15:0] tbl_addr [NSLOT];
    logic [15:0] tbl_shadow [NSLOT];
    int          tbl_count;
    logic        stepping;
    logic        ret_pending;
    logic [15:0] ret_addr;

    bwu_pkg::result_t pending_results[$];
    int          mismatches;
    int          checked;
    int          sent;
    int          cycles;
    int          burst_left;
    logic        hold_off;
    int          hold_cycles;

    initial begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    function automatic logic slot_fires(int i, logic [15:0] pc);
        case (tbl_kind[i])
            bwu_pkg::KIND_PC: return tbl_addr[i] == pc;
            bwu_pkg::KIND_W8: return {8'h00, tbl_shadow[i][7:0]} == tbl_cmp[i];
            bwu_pkg::KIND_W16: return tbl_shadow[i] == tbl_cmp[i];
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic opcode_is_call(logic [7:0] b);
        case (b)
            8'hc4, 8'hcc, 8'hcd, 8'hd4, 8'hdc, 8'he4, 8'hec, 8'hf4: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bwu_pkg::result_t predict_debug_response(bwu_pkg::cmd_t c,
                                                                logic [7:0] ib);
        bwu_pkg::result_t r;
        int n;
        r = '0;
        n = c.entry_number;
        case (c.op)
            bwu_pkg::OP_STEP:
            begin
                if (stepping)
                begin
                    r.halt = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        if (tbl_on[i] && slot_fires(i, c.cur_pc))
                        begin
                            if (tbl_kind[i] != bwu_pkg::KIND_PC)
                                tbl_on[i] = 1'b0;
                            r.hit_number = 4'(i + 1);
                            r.halt = 1'b1;
                            break;
                        end
                    end
                    if (ret_pending && c.cur_pc == ret_addr)
                    begin
                        ret_pending = 1'b0;
                        r.halt = 1'b1;
                    end
                end
            end
            bwu_pkg::OP_ADD_PC, bwu_pkg::OP_ADD_W8, bwu_pkg::OP_ADD_W16:
            begin
                if (tbl_count >= NSLOT)
                begin
                    r.status = bwu_pkg::ST_FULL;
                end
                else
                begin
                    tbl_kind[tbl_count] = (c.op == bwu_pkg::OP_ADD_PC) ? bwu_pkg::KIND_PC :
                        (c.op == bwu_pkg::OP_ADD_W8) ? bwu_pkg::KIND_W8 : bwu_pkg::KIND_W16;
                    tbl_on[tbl_count] = 1'b1;
                    tbl_addr[tbl_count] = c.target_addr;
                    tbl_cmp[tbl_count] = (c.op == bwu_pkg::OP_ADD_PC) ? 16'h0 : c.match_value;
                    tbl_shadow[tbl_count] = (c.op == bwu_pkg::OP_ADD_PC) ? 16'h0 :
                        c.initial_word;
                    tbl_count++;
                end
            end
            bwu_pkg::OP_DELETE:
            begin
                if (n == 0 || n > tbl_count)
                begin
                    r.status = bwu_pkg::ST_NO_ENTRY;
                end
                else
                begin
                    for (int i = n - 1; i + 1 < tbl_count; i++)
                    begin
                        tbl_kind[i] = tbl_kind[i + 1];
                        tbl_on[i] = tbl_on[i + 1];
                        tbl_cmp[i] = tbl_cmp[i + 1];
                        tbl_addr[i] = tbl_addr[i + 1];
                        tbl_shadow[i] = tbl_shadow[i + 1];
                    end
                    tbl_count--;
                    tbl_on[tbl_count] = 1'b0;
                end
            end
            bwu_pkg::OP_ENABLE, bwu_pkg::OP_DISABLE:
            begin
                if (n == 0 || n > tbl_count)
                    r.status = bwu_pkg::ST_NO_ENTRY;
                else
                    tbl_on[n - 1] = (c.op == bwu_pkg::OP_ENABLE);
            end
            bwu_pkg::OP_MEM_WRITE:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_kind[i] != bwu_pkg::KIND_PC)
                    begin
                        if (tbl_addr[i] == c.target_addr)
                            tbl_shadow[i][7:0] = c.write_byte;
                        if (tbl_kind[i] == bwu_pkg::KIND_W16 &&
                            16'(tbl_addr[i] + 16'd1) == c.target_addr)
                            tbl_shadow[i][15:8] = c.write_byte;
                    end
                end
            end
            bwu_pkg::OP_CONTINUE: stepping = 1'b0;
            bwu_pkg::OP_SINGLE: stepping = 1'b1;
            bwu_pkg::OP_NEXT:
            begin
                if (opcode_is_call(ib))
                begin
                    stepping = 1'b0;
                    ret_pending = 1'b1;
                    ret_addr = 16'(c.cur_pc + {13'd0, c.instr_len});
                end
                else
                begin
                    stepping = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_command(logic [3:0] o, logic [15:0] pc, logic [15:0] a,
                                logic [15:0] v, logic [3:0] n, logic [7:0] wb,
                                logic [15:0] iw, logic [7:0] ib, logic [2:0] il);
        bwu_pkg::cmd_t c;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        c = '0;
        c.op = o;
        c.cur_pc = pc;
        c.target_addr = a;
        c.match_value = v;
        c.entry_number = n;
        c.write_byte = wb;
        c.initial_word = iw;
        c.instr_len = il;
        push <= 1'b1;
        op <= o;
        cur_pc <= pc;
        target_addr <= a;
        match_value <= v;
        entry_number <= n;
        write_byte <= wb;
        initial_word <= iw;
        instr_byte <= ib;
        instr_len <= il;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_debug_response(c, ib));
        sent++;
        @(negedge clk);
    endtask

    task automatic send_random(logic [3:0] o);
        logic [7:0] ib;
        logic [15:0] a;
        ib = ($urandom_range(0, 1) == 1) ? 8'hcd : 8'($urandom);
        a = ($urandom_range(0, 2) == 0 && tbl_count > 0) ?
            tbl_addr[$urandom_range(0, tbl_count - 1)] + 16'($urandom_range(0, 1)) :
            16'($urandom);
        send_command(o, ($urandom_range(0, 1) == 1) ? ret_addr : 16'($urandom), a,
                     ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 255)) : 16'($urandom),
                     4'($urandom_range(0, 15)), 8'($urandom), 16'($urandom),
                     ib, 3'($urandom));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (NSLOT + 8) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && pop && !empty)
        begin
            bwu_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transfer: halt=%0b hit=%0d status=%0d",
                             halt, hit_number, status);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (want.halt !== halt || want.hit_number !== hit_number ||
                    want.status !== status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch %0d: expected %0b/%0d/%0d got %0b/%0d/%0d",
                                 checked, want.halt, want.hit_number, want.status,
                                 halt, hit_number, status);
                end
            end
        end
    end

    // The receiver stalls at random, or not at all, unless held off.
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else if ((cycles / 200) % 3 == 0)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    task automatic test_directed();
        send_command(bwu_pkg::OP_STEP, 16'h0, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_DELETE, 16'h0, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_ENABLE, 16'h0, 16'h0, 16'h0, 4'd1, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_ADD_PC, 16'h0, 16'hffff, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0,
                     3'd1);
        send_command(bwu_pkg::OP_ADD_W8, 16'h0, 16'h1234, 16'h0155, 4'd0, 8'h0, 16'h0055,
                     8'h0, 3'd1);
        send_command(bwu_pkg::OP_ADD_W8, 16'h0, 16'h1234, 16'h0077, 4'd0, 8'h0, 16'h0, 8'h0,
                     3'd1);
        send_command(bwu_pkg::OP_ADD_W16, 16'h0, 16'hffff, 16'hbeef, 4'd0, 8'h0, 16'h0, 8'h0,
                     3'd1);
        send_command(bwu_pkg::OP_CONTINUE, 16'h0, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_STEP, 16'hffff, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_MEM_WRITE, 16'h0, 16'h1234, 16'h0, 4'd0, 8'h77, 16'h0, 8'h0,
                     3'd1);
        send_command(bwu_pkg::OP_MEM_WRITE, 16'h0, 16'hffff, 16'h0, 4'd0, 8'hef, 16'h0, 8'h0,
                     3'd1);
        send_command(bwu_pkg::OP_MEM_WRITE, 16'h0, 16'h0000, 16'h0, 4'd0, 8'hbe, 16'h0, 8'h0,
                     3'd1);
        send_command(bwu_pkg::OP_DISABLE, 16'h0, 16'h0, 16'h0, 4'd1, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_STEP, 16'hffff, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_STEP, 16'hffff, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_NEXT, 16'hfffe, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'hf4, 3'd7);
        send_command(bwu_pkg::OP_STEP, 16'h0005, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_NEXT, 16'h0, 16'h0, 16'h0, 4'd0, 8'h0, 16'h0, 8'h00, 3'd1);
        send_command(bwu_pkg::OP_DELETE, 16'h0, 16'h0, 16'h0, 4'd2, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(bwu_pkg::OP_ENABLE, 16'h0, 16'h0, 16'h0, 4'd15, 8'h0, 16'h0, 8'h0, 3'd1);
        send_command(4'd15, 16'hffff, 16'hffff, 16'hffff, 4'd15, 8'hff, 16'hffff, 8'hff, 3'd7);
        for (int i = 0; i < NSLOT; i++)
            send_command(bwu_pkg::OP_ADD_PC, 16'h0, 16'(i), 16'h0, 4'd0, 8'h0, 16'h0, 8'h0,
                         3'd1);
        send_command(bwu_pkg::OP_DELETE, 16'h0, 16'h0, 16'h0, 4'd8, 8'h0, 16'h0, 8'h0, 3'd1);
        drain_results();
    endtask

    task automatic test_random_sessions();
        int r;
        for (int k = 0; k < 1300; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_random(bwu_pkg::OP_STEP);
            else if (r < 45)
                send_random(4'($urandom_range(bwu_pkg::OP_ADD_PC, bwu_pkg::OP_ADD_W16)));
            else if (r < 55)
                send_random(bwu_pkg::OP_DELETE);
            else if (r < 65)
                send_random(4'($urandom_range(bwu_pkg::OP_ENABLE, bwu_pkg::OP_DISABLE)));
            else if (r < 83)
                send_random(bwu_pkg::OP_MEM_WRITE);
            else if (r < 97)
                send_random(4'($urandom_range(bwu_pkg::OP_CONTINUE, bwu_pkg::OP_NEXT)));
            else
                send_random(4'($urandom_range(11, 15)));
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_cycles = 0;
        hold_off = 1'b1;
        fork
            begin
                while (hold_cycles < 300)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 40; k++)
                send_random(bwu_pkg::OP_STEP);
        join
        drain_results();
        for (int k = 0; k < 60; k++)
            send_random(4'($urandom_range(0, 10)));
        drain_results();
    endtask

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        op = '0;
        cur_pc = '0;
        target_addr = '0;
        match_value = '0;
        entry_number = '0;
        write_byte = '0;
        initial_word = '0;
        instr_byte = '0;
        instr_len = 3'd1;
        pop = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        mismatches = 0;
        checked = 0;
        sent = 0;
        cycles = 0;
        burst_left = 0;
        tbl_count = 0;
        stepping = 1'b1;
        ret_pending = 1'b0;
        ret_addr = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_on[i] = 1'b0;
            tbl_kind[i] = bwu_pkg::KIND_PC;
            tbl_cmp[i] = '0;
            tbl_addr[i] = '0;
            tbl_shadow[i] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_sessions();
        test_backpressure();
        $display("Sent %0d debug commands and checked %0d responses, %0d mismatches.",
                 sent, checked, mismatches);
        $display("Covered breakpoints, byte and word watches, compaction, step-over and stalls.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/bwu_pkg.sv
sv/bwu_front.sv
sv/bwu_back.sv
sv/breakpoint_watch_unit.sv
dv/breakpoint_watch_unit_test.sv
